// ----- src/rcd_pkg.sv -----
// Shared types, constants and helpers of the chunk-stream deframer.
`default_nettype none

package rcd_pkg;

	localparam int NUM_CHANNELS = 64;
	localparam int CHAN_W = $clog2(NUM_CHANNELS);

	localparam logic [23:0] CHUNK_SIZE_RESET = 24'd128;

	// Message header formats taken from the basic header byte.
	localparam logic [1:0] FMT_FULL = 2'd0;
	localparam logic [1:0] FMT_NO_SID = 2'd1;
	localparam logic [1:0] FMT_TS_ONLY = 2'd2;
	localparam logic [1:0] FMT_NONE = 2'd3;

	// Per-channel message state kept in the channel table.
	typedef struct packed {
		logic [23:0] timestamp;
		logic [23:0] body_length;
		logic [7:0]  msg_type;
		logic [31:0] stream_id;
		logic [23:0] bytes_done;
	} chan_entry_t;

	localparam int ENTRY_W = $bits(chan_entry_t);

	// Write request from the parser into the channel table.
	typedef struct packed {
		logic              en;
		logic [CHAN_W-1:0] addr;
		chan_entry_t       data;
	} tbl_wr_t;

	// One result item produced by the parser.
	typedef struct packed {
		logic              valid;
		logic [CHAN_W-1:0] channel;
		logic [7:0]        msg_type;
		logic [23:0]       timestamp;
		logic [31:0]       stream_id;
		logic [23:0]       body_length;
		logic [23:0]       byte_offset;
		logic [7:0]        data_byte;
		logic              has_byte;
		logic              last_of_message;
	} result_t;

	// Message header bytes that follow the basic header, per format.
	function automatic logic [3:0] hdr_bytes(input logic [1:0] fmt);
		logic [3:0] n;
		unique case (fmt)
			FMT_FULL:    n = 4'd11;
			FMT_NO_SID:  n = 4'd7;
			FMT_TS_ONLY: n = 4'd3;
			default:     n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- src/rtmp_chunk_deframer_top.sv -----
// A result passes through the input stage and then the output register.
// Throughput: one byte per cycle unless the output stalls; each byte does one read-modify-write of
// the 64-entry channel table, read ahead from the input stage and forwarded from the working entry.
// Reset clears all parse state and marks every table entry empty through per-entry valid bits,
// so the block takes bytes as soon as reset is released; chunk_size resets to 128.
`default_nettype none

module rtmp_chunk_deframer_top
	import rcd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [23:0]  cfg_wr_data,   // chunk_size
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // in_byte
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// channel[5:0], msg_type[13:6], timestamp[37:14], stream_id[69:38],
	// body_length[93:70], byte_offset[117:94], data_byte[125:118], zero[127:126]
	output logic [127:0]      m_axis_tdata,
	output logic              m_axis_tuser,  // has_byte
	output logic              m_axis_tlast   // last_of_message
);

	logic [23:0]       chunk_size_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              fire;
	logic              s_accept;
	logic [CHAN_W-1:0] rd_addr;
	chan_entry_t       rd_entry;
	result_t           res;
	tbl_wr_t           tbl_wr;
	logic [CHAN_W-1:0] cur_chan;
	chan_entry_t       cur_entry;
	logic              out_valid_s2;
	result_t           out_s2;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_SIZE_RESET;
		end else if (cfg_wr_en) begin
			chunk_size_q <= cfg_wr_data;
		end
	end

	// Handshake: a byte is processed when the output register can take its result.
	assign fire = valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;
	assign s_accept = s_axis_tvalid && s_axis_tready;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Look up the channel named by the byte entering the input stage, or the one held there.
	assign rd_addr = s_accept ? s_axis_tdata[CHAN_W-1:0] : byte_s1[CHAN_W-1:0];

	rcd_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.look_idx (byte_s1[CHAN_W-1:0]),
		.wr       (tbl_wr),
		.fwd_chan (cur_chan),
		.fwd_entry(cur_entry),
		.rd_entry (rd_entry)
	);

	rcd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.in_byte   (byte_s1),
		.chunk_size(chunk_size_q),
		.rd_entry  (rd_entry),
		.res       (res),
		.tbl_wr    (tbl_wr),
		.cur_chan  (cur_chan),
		.cur_entry (cur_entry)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (!out_valid_s2 || m_axis_tready) begin
			out_valid_s2 <= fire && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			out_s2 <= res;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata = {2'b00, out_s2.data_byte, out_s2.byte_offset, out_s2.body_length,
		out_s2.stream_id, out_s2.timestamp, out_s2.msg_type, out_s2.channel};
	assign m_axis_tuser = out_s2.has_byte;
	assign m_axis_tlast = out_s2.last_of_message;

endmodule

`default_nettype wire

// ----- src/rcd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a read of the entry being written returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/rcd_table.sv -----
// Per-channel table: RAM, reset valid bits and forwarding of the working entry.
`default_nettype none

module rcd_table
	import rcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CHAN_W-1:0] rd_addr,
	input  wire logic [CHAN_W-1:0] look_idx,
	input  wire tbl_wr_t           wr,
	input  wire logic [CHAN_W-1:0] fwd_chan,
	input  wire chan_entry_t       fwd_entry,
	output chan_entry_t            rd_entry
);

	logic [NUM_CHANNELS-1:0] valid_q;
	logic [ENTRY_W-1:0]      ram_rdata;

	rcd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_CHANNELS)
	) u_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// An entry reads as zero until it has been written once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// The working entry is always newest for the current channel, so it wins over the RAM.
	always_comb begin
		if (look_idx == fwd_chan) begin
			rd_entry = fwd_entry;
		end else if (valid_q[look_idx]) begin
			rd_entry = chan_entry_t'(ram_rdata);
		end else begin
			rd_entry = '0;
		end
	end

endmodule

`default_nettype wire

// ----- src/rcd_parser.sv -----
// Chunk parser: header collection, body counting and the working channel entry.
`default_nettype none

module rcd_parser
	import rcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        in_byte,
	input  wire logic [23:0]       chunk_size,
	input  wire chan_entry_t       rd_entry,
	output result_t                res,
	output tbl_wr_t                tbl_wr,
	output logic [CHAN_W-1:0]      cur_chan,
	output chan_entry_t            cur_entry
);

	localparam logic [1:0] PH_HDR  = 2'd0;
	localparam logic [1:0] PH_MSG  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	logic [1:0]        phase_q, phase_n;
	logic [3:0]        hdr_left_q, hdr_left_n;
	logic [1:0]        fmt_q, fmt_n;
	logic [CHAN_W-1:0] chan_q, chan_n;
	logic [55:0]       hs_q, hs_n;
	logic [31:0]       sid_q, sid_n;
	logic [23:0]       chunk_left_q, chunk_left_n;
	chan_entry_t       ent_q, ent_n;

	logic [3:0]  total;
	logic [3:0]  hdr_idx;
	logic        do_apply;
	logic [23:0] rem;
	logic [23:0] chunk;
	logic [23:0] done_inc;
	logic        last;

	// Next-state logic for one accepted byte.
	always_comb begin
		phase_n = phase_q;
		hdr_left_n = hdr_left_q;
		fmt_n = fmt_q;
		chan_n = chan_q;
		hs_n = hs_q;
		sid_n = sid_q;
		chunk_left_n = chunk_left_q;
		ent_n = ent_q;
		res = '0;
		do_apply = 1'b0;
		total = hdr_bytes(fmt_q);
		hdr_idx = '0;
		rem = '0;
		chunk = '0;
		done_inc = ent_q.bytes_done + 24'd1;
		last = 1'b0;

		unique case (phase_q)
			PH_MSG: begin
				// Header bytes: the first seven go to the header word, the rest to the stream id.
				hdr_idx = (hdr_left_q <= total) ? total - hdr_left_q : 4'd0;
				if (hdr_idx < 4'd7) begin
					hs_n = {hs_q[47:0], in_byte};
				end else begin
					sid_n = {sid_q[23:0], in_byte};
				end
				hdr_left_n = (hdr_left_q != 4'd0) ? hdr_left_q - 4'd1 : 4'd0;
				if (hdr_left_n == 4'd0) begin
					do_apply = 1'b1;
				end
			end
			PH_BODY: begin
				// Body byte: emit it and advance the channel's byte count.
				last = (done_inc >= ent_q.body_length);
				res.valid = 1'b1;
				res.byte_offset = ent_q.bytes_done;
				res.data_byte = in_byte;
				res.has_byte = 1'b1;
				res.last_of_message = last;
				ent_n.bytes_done = done_inc;
				chunk_left_n = (chunk_left_q != 24'd0) ? chunk_left_q - 24'd1 : 24'd0;
				if (last) begin
					ent_n.bytes_done = '0;
					chunk_left_n = '0;
					phase_n = PH_HDR;
				end else if (chunk_left_n == 24'd0) begin
					phase_n = PH_HDR;
				end
			end
			default: begin
				// Basic header byte: switch to the channel's stored entry.
				fmt_n = in_byte[7:6];
				chan_n = in_byte[CHAN_W-1:0];
				hs_n = '0;
				sid_n = '0;
				ent_n = rd_entry;
				hdr_left_n = hdr_bytes(in_byte[7:6]);
				if (in_byte[7:6] == FMT_NONE) begin
					do_apply = 1'b1;
				end else begin
					phase_n = PH_MSG;
				end
			end
		endcase

		// End of the message header: merge the new fields and size the chunk body.
		if (do_apply) begin
			if (fmt_n == FMT_FULL || fmt_n == FMT_NO_SID) begin
				ent_n.timestamp = hs_n[55:32];
				ent_n.body_length = hs_n[31:8];
				ent_n.msg_type = hs_n[7:0];
				ent_n.bytes_done = '0;
				if (fmt_n == FMT_FULL) begin
					ent_n.stream_id = sid_n;
				end
			end else if (fmt_n == FMT_TS_ONLY) begin
				ent_n.timestamp = hs_n[23:0];
			end
			rem = (ent_n.body_length > ent_n.bytes_done) ?
				ent_n.body_length - ent_n.bytes_done : 24'd0;
			chunk = (chunk_size < rem) ? chunk_size : rem;
			phase_n = PH_HDR;
			chunk_left_n = '0;
			if (rem == 24'd0) begin
				ent_n.bytes_done = '0;
				res.valid = 1'b1;
				res.last_of_message = 1'b1;
			end else if (chunk != 24'd0) begin
				chunk_left_n = chunk;
				phase_n = PH_BODY;
			end
		end

		// Message fields of a result come from the updated entry.
		res.channel = chan_n;
		res.msg_type = ent_n.msg_type;
		res.timestamp = ent_n.timestamp;
		res.stream_id = ent_n.stream_id;
		res.body_length = ent_n.body_length;
	end

	// Parse state and working entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			hdr_left_q <= '0;
			fmt_q <= '0;
			chan_q <= '0;
			hs_q <= '0;
			sid_q <= '0;
			chunk_left_q <= '0;
			ent_q <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			hdr_left_q <= hdr_left_n;
			fmt_q <= fmt_n;
			chan_q <= chan_n;
			hs_q <= hs_n;
			sid_q <= sid_n;
			chunk_left_q <= chunk_left_n;
			ent_q <= ent_n;
		end
	end

	// Every processed byte writes the working entry back to its channel.
	always_comb begin
		tbl_wr.en = fire;
		tbl_wr.addr = chan_n;
		tbl_wr.data = ent_n;
	end

	assign cur_chan = chan_q;
	assign cur_entry = ent_q;

endmodule

`default_nettype wire

// ----- tb/chunk_stream_checker.sv -----
// Scoreboard for the chunk-stream deframer: predicts each result from the accepted bytes and compares.
module chunk_stream_checker
	import rcd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [23:0]  cfg_wr_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [127:0] m_axis_tdata,
	input  logic         m_axis_tuser,
	input  logic         m_axis_tlast,
	output int           field_errors,
	output int           results_owed,
	output int           results_checked,
	output int           message_ends,
	output int           empty_messages
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		WAIT_BASIC = 2'd0,
		IN_HEADER  = 2'd1,
		IN_BODY    = 2'd2
	} parse_phase_e;

	// One body byte or empty-message marker, with the fields of its message.
	typedef struct packed {
		logic [5:0]  channel;
		logic [7:0]  msg_type;
		logic [23:0] timestamp;
		logic [31:0] stream_id;
		logic [23:0] body_length;
		logic [23:0] byte_offset;
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        last_of_message;
	} msg_byte_t;

	msg_byte_t expected_bytes[$];

	// Parser state as the deframer should hold it.
	parse_phase_e phase;
	logic [3:0]   hdr_left;
	logic [5:0]   cur_chan;
	logic [1:0]   cur_fmt;
	logic [55:0]  hdr_shift;
	logic [31:0]  sid_shift;
	logic [23:0]  chunk_left;
	logic [23:0]  chunk_size;

	// Per-channel message table.
	logic [23:0] tbl_ts[NUM_CHANNELS];
	logic [23:0] tbl_len[NUM_CHANNELS];
	logic [7:0]  tbl_type[NUM_CHANNELS];
	logic [31:0] tbl_sid[NUM_CHANNELS];
	logic [23:0] tbl_done[NUM_CHANNELS];

	// Message header bytes that follow the basic header.
	function automatic logic [3:0] header_len(input logic [1:0] fmt);
		case (fmt)
			FMT_FULL:    return 4'd11;
			FMT_NO_SID:  return 4'd7;
			FMT_TS_ONLY: return 4'd3;
			default:     return 4'd0;
		endcase
	endfunction

	function automatic void expect_result(input logic [23:0] offset, input logic [7:0] data,
			input logic has, input logic last);
		msg_byte_t r;
		r.channel = cur_chan;
		r.msg_type = tbl_type[cur_chan];
		r.timestamp = tbl_ts[cur_chan];
		r.stream_id = tbl_sid[cur_chan];
		r.body_length = tbl_len[cur_chan];
		r.byte_offset = offset;
		r.data_byte = data;
		r.has_byte = has;
		r.last_of_message = last;
		expected_bytes.insert(expected_bytes.size(), r);
	endfunction

	// Formats 0 and 1 restart the message; format 2 only refreshes the timestamp.
	function automatic void commit_header();
		if (cur_fmt == FMT_FULL || cur_fmt == FMT_NO_SID) begin
			tbl_ts[cur_chan] = hdr_shift[55:32];
			tbl_len[cur_chan] = hdr_shift[31:8];
			tbl_type[cur_chan] = hdr_shift[7:0];
			tbl_done[cur_chan] = 24'd0;
			if (cur_fmt == FMT_FULL) begin
				tbl_sid[cur_chan] = sid_shift;
			end
		end else if (cur_fmt == FMT_TS_ONLY) begin
			tbl_ts[cur_chan] = hdr_shift[23:0];
		end
	endfunction

	// Size the chunk body, or report an empty message right away.
	function automatic void open_body();
		logic [23:0] len;
		logic [23:0] done;
		logic [23:0] rem;
		logic [23:0] span;
		len = tbl_len[cur_chan];
		done = tbl_done[cur_chan];
		rem = (len > done) ? len - done : 24'd0;
		phase = WAIT_BASIC;
		chunk_left = 24'd0;
		if (rem == 24'd0) begin
			tbl_done[cur_chan] = 24'd0;
			expect_result(24'd0, 8'd0, 1'b0, 1'b1);
		end else begin
			span = (chunk_size < rem) ? chunk_size : rem;
			if (span != 24'd0) begin
				chunk_left = span;
				phase = IN_BODY;
			end
		end
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		logic [3:0]  total;
		logic [3:0]  idx;
		logic [23:0] len;
		logic [23:0] off;
		logic [23:0] done_next;
		logic        last;
		case (phase)
			IN_HEADER: begin
				// The first seven header bytes go to the field register, the rest to the stream id.
				total = header_len(cur_fmt);
				idx = (hdr_left <= total) ? total - hdr_left : 4'd0;
				if (idx < 4'd7) begin
					hdr_shift = {hdr_shift[47:0], b};
				end else begin
					sid_shift = {sid_shift[23:0], b};
				end
				hdr_left = (hdr_left > 4'd0) ? hdr_left - 4'd1 : 4'd0;
				if (hdr_left == 4'd0) begin
					commit_header();
					open_body();
				end
			end
			IN_BODY: begin
				len = tbl_len[cur_chan];
				off = tbl_done[cur_chan];
				done_next = off + 24'd1;
				last = (done_next >= len);
				expect_result(off, b, 1'b1, last);
				tbl_done[cur_chan] = done_next;
				chunk_left = (chunk_left > 24'd0) ? chunk_left - 24'd1 : 24'd0;
				if (last) begin
					tbl_done[cur_chan] = 24'd0;
					chunk_left = 24'd0;
					phase = WAIT_BASIC;
				end else if (chunk_left == 24'd0) begin
					phase = WAIT_BASIC;
				end
			end
			default: begin
				// Basic header: format in the top two bits, channel below.
				cur_fmt = b[7:6];
				cur_chan = b[5:0];
				hdr_shift = 56'd0;
				sid_shift = 32'd0;
				hdr_left = header_len(b[7:6]);
				if (hdr_left == 4'd0) begin
					commit_header();
					open_body();
				end else begin
					phase = IN_HEADER;
				end
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] seen_v);
		if (want_v !== seen_v) begin
			field_errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want_v, seen_v);
		end
	endfunction

	// Predict on every input transfer, compare on every output transfer.
	always @(posedge clk or negedge arst_n) begin
		msg_byte_t seen;
		msg_byte_t want;
		if (!arst_n) begin
			phase = WAIT_BASIC;
			hdr_left = 4'd0;
			cur_chan = 6'd0;
			cur_fmt = FMT_FULL;
			hdr_shift = 56'd0;
			sid_shift = 32'd0;
			chunk_left = 24'd0;
			chunk_size = CHUNK_SIZE_RESET;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				tbl_ts[i] = 24'd0;
				tbl_len[i] = 24'd0;
				tbl_type[i] = 8'd0;
				tbl_sid[i] = 32'd0;
				tbl_done[i] = 24'd0;
			end
			expected_bytes.delete();
			field_errors = 0;
			results_owed = 0;
			results_checked = 0;
			message_ends = 0;
			empty_messages = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				deframe_byte(s_axis_tdata);
			end
			if (cfg_wr_en) begin
				chunk_size = cfg_wr_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				seen.channel = m_axis_tdata[5:0];
				seen.msg_type = m_axis_tdata[13:6];
				seen.timestamp = m_axis_tdata[37:14];
				seen.stream_id = m_axis_tdata[69:38];
				seen.body_length = m_axis_tdata[93:70];
				seen.byte_offset = m_axis_tdata[117:94];
				seen.data_byte = m_axis_tdata[125:118];
				seen.has_byte = m_axis_tuser;
				seen.last_of_message = m_axis_tlast;
				if (expected_bytes.size() == 0) begin
					field_errors++;
					$display("%0t: unexpected result: expected none actual %h", $time, seen);
				end else begin
					want = expected_bytes.pop_front();
					results_checked++;
					if (want.last_of_message) begin
						message_ends++;
					end
					if (!want.has_byte) begin
						empty_messages++;
					end
					check_field("channel", 32'(want.channel), 32'(seen.channel));
					check_field("msg_type", 32'(want.msg_type), 32'(seen.msg_type));
					check_field("timestamp", 32'(want.timestamp), 32'(seen.timestamp));
					check_field("stream_id", want.stream_id, seen.stream_id);
					check_field("body_length", 32'(want.body_length), 32'(seen.body_length));
					check_field("byte_offset", 32'(want.byte_offset), 32'(seen.byte_offset));
					check_field("data_byte", 32'(want.data_byte), 32'(seen.data_byte));
					check_field("has_byte", 32'(want.has_byte), 32'(seen.has_byte));
					check_field("last_of_message", 32'(want.last_of_message),
						32'(seen.last_of_message));
				end
			end
			results_owed = expected_bytes.size();
		end
	end

endmodule

// ----- tb/tb_rtmp_chunk_deframer_top.sv -----
// Testbench top for the chunk-stream deframer: clock, reset, byte stimulus and verdict.
module tb_rtmp_chunk_deframer_top;
	import rcd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [23:0]  cfg_wr_data = 24'd0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'd0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	int field_errors;
	int results_owed;
	int results_checked;
	int message_ends;
	int empty_messages;

	// Traffic shaping shared with the receiver process.
	int gap_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int unsigned bytes_sent = 0;

	// Framing view of the stream, so that each chunk carries the right body size.
	logic [23:0] plan_cs = CHUNK_SIZE_RESET;
	logic [23:0] plan_len[NUM_CHANNELS];
	logic [23:0] plan_done[NUM_CHANNELS];
	logic [5:0]  busy_chans[5] = '{6'd0, 6'd1, 6'd31, 6'd62, 6'd63};
	int          gap_mix[4] = '{0, 69, 0, 31};
	int          stall_mix[4] = '{0, 0, 69, 31};

	always #2 clk = ~clk;

	rtmp_chunk_deframer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	chunk_stream_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.field_errors    (field_errors),
		.results_owed    (results_owed),
		.results_checked (results_checked),
		.message_ends    (message_ends),
		.empty_messages  (empty_messages)
	);

	// Offer one byte and hold it until the transfer; called and returning at a falling edge.
	task automatic push_byte(input logic [7:0] b);
		while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
		bytes_sent++;
	endtask

	// Send one chunk: basic header, the header bytes of its format, then its body.
	task automatic send_chunk(input logic [1:0] fmt, input logic [5:0] ch, input logic [23:0] ts,
			input logic [23:0] len, input logic [7:0] mtype, input logic [31:0] sid);
		logic [23:0] rem;
		logic [23:0] span;
		push_byte({fmt, ch});
		if (fmt != FMT_NONE) begin
			push_byte(ts[23:16]);
			push_byte(ts[15:8]);
			push_byte(ts[7:0]);
		end
		if (fmt == FMT_FULL || fmt == FMT_NO_SID) begin
			push_byte(len[23:16]);
			push_byte(len[15:8]);
			push_byte(len[7:0]);
			push_byte(mtype);
			plan_len[ch] = len;
			plan_done[ch] = 24'd0;
		end
		if (fmt == FMT_FULL) begin
			push_byte(sid[31:24]);
			push_byte(sid[23:16]);
			push_byte(sid[15:8]);
			push_byte(sid[7:0]);
		end
		rem = (plan_len[ch] > plan_done[ch]) ? plan_len[ch] - plan_done[ch] : 24'd0;
		if (rem == 24'd0) begin
			plan_done[ch] = 24'd0;
		end else begin
			span = (plan_cs < rem) ? plan_cs : rem;
			repeat (span) begin
				push_byte(8'($urandom_range(0, 255)));
			end
			plan_done[ch] = plan_done[ch] + span;
			if (plan_done[ch] >= plan_len[ch]) begin
				plan_done[ch] = 24'd0;
			end
		end
	endtask

	// Stop offering and wait until every predicted result has left the block.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (results_owed != 0) begin
			@(negedge clk);
		end
		repeat (6) @(negedge clk);
	endtask

	// Mostly well-formed chunks on a few busy channels, with some random noise headers.
	task automatic run_traffic(input int unsigned budget);
		int unsigned start;
		int          pick;
		logic [5:0]  ch;
		logic [23:0] len;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			ch = ($urandom_range(0, 4) != 0) ? busy_chans[$urandom_range(0, 4)]
				: 6'($urandom_range(0, 63));
			pick = $urandom_range(0, 99);
			if (pick < 10 && plan_cs <= CHUNK_SIZE_RESET) begin
				send_chunk(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), 24'($urandom),
					24'($urandom), 8'($urandom), $urandom);
			end else if (pick < 50) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					len = 24'd0;
				end else if (pick < 90 || plan_cs > CHUNK_SIZE_RESET) begin
					len = 24'($urandom_range(1, 48));
				end else begin
					len = 24'($urandom);
				end
				send_chunk(($urandom_range(0, 1) != 0) ? FMT_FULL : FMT_NO_SID, ch,
					24'($urandom), len, 8'($urandom), $urandom);
			end else if (pick < 65) begin
				send_chunk(FMT_TS_ONLY, ch, 24'($urandom), 24'd0, 8'd0, 32'd0);
			end else begin
				send_chunk(FMT_NONE, ch, 24'd0, 24'd0, 8'd0, 32'd0);
			end
		end
	endtask

	// Receiver: random stalls, plus one long hold-off when asked.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !(stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Main sequence: reset, directed chunks, then one phase per chunk size.
	initial begin : stimulus
		logic [23:0] cs;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			plan_len[i] = 24'd0;
			plan_done[i] = 24'd0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: full header with extreme fields, continuation of a completed message,
		// timestamp-only chunk on a fresh channel, and an empty message from a short header.
		send_chunk(FMT_FULL, 6'd0, 24'hFFFFFF, 24'd1, 8'hFF, 32'h8000_0001);
		send_chunk(FMT_NONE, 6'd0, 24'd0, 24'd0, 8'd0, 32'd0);
		send_chunk(FMT_TS_ONLY, 6'd63, 24'h000000, 24'd0, 8'd0, 32'd0);
		send_chunk(FMT_NO_SID, 6'd63, 24'h7FFFFF, 24'd0, 8'h00, 32'd0);

		// The largest chunk size runs first, before noise can leave long messages open.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0:       cs = 24'hFFFFFF;
				1:       cs = 24'd1;
				2:       cs = CHUNK_SIZE_RESET;
				3:       cs = 24'($urandom_range(2, 24));
				4:       cs = 24'($urandom_range(1, 64));
				default: cs = 24'd5;
			endcase
			settle();
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= cs;
			@(negedge clk);
			cfg_wr_en <= 1'b0;
			plan_cs = cs;
			gap_pct = gap_mix[p % 4];
			stall_pct = stall_mix[p % 4];
			if (p == 2) begin
				hold_req = 1'b1;
			end
			if (p == 3) begin
				// Let the output drain completely in the middle of the stream.
				run_traffic(100);
				settle();
				run_traffic(105);
			end else begin
				run_traffic(205);
			end
		end

		settle();
		repeat (16) @(negedge clk);
		$display("Run covered %0d stream bytes over six chunk sizes from 1 to 16777215,",
			bytes_sent);
		$display("four idle mixes and %0d results (%0d message ends, %0d empty messages).",
			results_checked, message_ends, empty_messages);
		if (field_errors == 0 && results_owed == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
src/rcd_pkg.sv
src/rcd_ram.sv
src/rcd_table.sv
src/rcd_parser.sv
src/rtmp_chunk_deframer_top.sv
tb/chunk_stream_checker.sv
tb/tb_rtmp_chunk_deframer_top.sv
